>>> design/skt_pkg.sv
// Shared types and constants for the sorted key table search and insert core.
// Holds the sequencer state type, the table entry layout and the status codes.
// No dependencies.
package skt_pkg;

   localparam int KEY_HALF_W = 64;
   localparam int OFFSET_W   = 32;
   localparam int POS_W      = 7;
   localparam int STATUS_W   = 2;

   localparam logic KIND_LOOKUP = 1'b0;
   localparam logic KIND_INSERT = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_SEARCH,
      SEQ_COMPARE,
      SEQ_SHIFT,
      SEQ_PUT
   } seq_state_type;

   typedef struct packed {
      logic [KEY_HALF_W-1:0] key_high;
      logic [KEY_HALF_W-1:0] key_low;
      logic [OFFSET_W-1:0]   offset;
   } entry_type;

   typedef struct packed {
      logic less;
      logic equal;
   } cmp_result_type;

endpackage

>>> design/sorted_key_table_search_insert_core.sv
// Top level of the sorted key table: search and insert sequencer.
// Depends on skt_pkg, skt_entry_ram and skt_key_compare.
//
// A request is taken at a rising edge where start is high and busy is low.
// Its fields are req_kind (0 lookup, 1 insert), the 128-bit key split into
// req_key_high and req_key_low, and req_data_offset for inserts.
// Exactly one response follows per request, shown for one cycle with
// rsp_valid high; the receiver cannot stall it.
// A lookup runs one binary search step at a time, each a read through the
// single read port of the table memory followed by a compare in the one
// shared key comparator. The response leaves at the end of the search.
// An insert then shifts the entries from the insertion point on up by one
// place and writes the new entry at that point; busy stays high until the
// table write is done.
// Reset clears the entry count, so the table starts empty and no clearing
// pass is needed. A full table rejects inserts of new keys with status 3.
module sorted_key_table_search_insert_core
   import skt_pkg::*;
#(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_kind,
   input  logic [KEY_HALF_W-1:0] req_key_high,
   input  logic [KEY_HALF_W-1:0] req_key_low,
   input  logic [OFFSET_W-1:0]   req_data_offset,
   output logic                  rsp_valid,
   output logic                  rsp_found,
   output logic [POS_W-1:0]      rsp_position,
   output logic [OFFSET_W-1:0]   rsp_stored_offset,
   output logic [STATUS_W-1:0]   rsp_status
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

   seq_state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic                  kind_ff, kind_in;
   logic [KEY_HALF_W-1:0] key_high_ff, key_high_in;
   logic [KEY_HALF_W-1:0] key_low_ff, key_low_in;
   logic [OFFSET_W-1:0]   offset_ff, offset_in;
   logic [CNT_W-1:0]      lo_ff, lo_in;
   logic [CNT_W-1:0]      hi_ff, hi_in;
   logic [CNT_W-1:0]      mid_ff, mid_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic                  hit_ff, hit_in;
   logic [OFFSET_W-1:0]   hit_offset_ff, hit_offset_in;

   logic                  found_ff, found_in;
   logic [POS_W-1:0]      position_ff, position_in;
   logic [OFFSET_W-1:0]   stored_offset_ff, stored_offset_in;
   logic [STATUS_W-1:0]   status_ff, status_in;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   entry_type        rd_data;
   cmp_result_type   cmp;

   logic [CNT_W-1:0]       mid_calc;
   logic [CNT_W-1:0]       count_less_one;
   logic [CNT_W-1:0]       idx_less_one;
   logic [CNT_W-1:0]       idx_less_two;
   logic [POS_W+CNT_W-1:0] pos_wide;

   skt_entry_ram #(
      .DEPTH(TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   skt_key_compare u_cmp (
      .stored_high (rd_data.key_high),
      .stored_low  (rd_data.key_low),
      .probe_high  (key_high_ff),
      .probe_low   (key_low_ff),
      .result      (cmp)
   );

   assign mid_calc       = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign count_less_one = count_ff - CNT_W'(1);
   assign idx_less_one   = idx_ff - CNT_W'(1);
   assign idx_less_two   = idx_ff - CNT_W'(2);
   assign pos_wide       = (POS_W + CNT_W)'(lo_ff);

   always_comb begin
      state_in         = state_ff;
      count_in         = count_ff;
      rsp_valid_in     = 1'b0;
      kind_in          = kind_ff;
      key_high_in      = key_high_ff;
      key_low_in       = key_low_ff;
      offset_in        = offset_ff;
      lo_in            = lo_ff;
      hi_in            = hi_ff;
      mid_in           = mid_ff;
      idx_in           = idx_ff;
      hit_in           = hit_ff;
      hit_offset_in    = hit_offset_ff;
      found_in         = found_ff;
      position_in      = position_ff;
      stored_offset_in = stored_offset_ff;
      status_in        = status_ff;
      wr_en            = 1'b0;
      wr_addr          = idx_ff[IDX_W-1:0];
      wr_data          = rd_data;
      rd_en            = 1'b0;
      rd_addr          = mid_calc[IDX_W-1:0];

      unique case (state_ff)
         SEQ_IDLE: begin
            if (start) begin
               kind_in     = req_kind;
               key_high_in = req_key_high;
               key_low_in  = req_key_low;
               offset_in   = req_data_offset;
               lo_in       = '0;
               hi_in       = count_ff;
               hit_in      = 1'b0;
               state_in    = SEQ_SEARCH;
            end
         end
         SEQ_SEARCH: begin
            if (lo_ff < hi_ff) begin
               rd_en    = 1'b1;
               rd_addr  = mid_calc[IDX_W-1:0];
               mid_in   = mid_calc;
               state_in = SEQ_COMPARE;
            end else begin
               rsp_valid_in = 1'b1;
               position_in  = pos_wide[POS_W-1:0];
               found_in     = hit_ff;
               state_in     = SEQ_IDLE;
               if (hit_ff) begin
                  stored_offset_in = hit_offset_ff;
                  status_in = (kind_ff == KIND_INSERT) ? STATUS_DUPLICATE : STATUS_OK;
               end else if (kind_ff == KIND_LOOKUP) begin
                  stored_offset_in = '0;
                  status_in        = STATUS_NOT_FOUND;
               end else if (count_ff == FULL_COUNT) begin
                  stored_offset_in = '0;
                  status_in        = STATUS_FULL;
               end else begin
                  stored_offset_in = offset_ff;
                  status_in        = STATUS_OK;
                  idx_in           = count_ff;
                  if (count_ff > lo_ff) begin
                     rd_en    = 1'b1;
                     rd_addr  = count_less_one[IDX_W-1:0];
                     state_in = SEQ_SHIFT;
                  end else begin
                     state_in = SEQ_PUT;
                  end
               end
            end
         end
         SEQ_COMPARE: begin
            if (cmp.less) begin
               lo_in = mid_ff + CNT_W'(1);
            end else begin
               hi_in = mid_ff;
            end
            if (cmp.equal) begin
               hit_in        = 1'b1;
               hit_offset_in = rd_data.offset;
            end
            state_in = SEQ_SEARCH;
         end
         SEQ_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[IDX_W-1:0];
            wr_data = rd_data;
            idx_in  = idx_less_one;
            if (idx_less_one > lo_ff) begin
               rd_en   = 1'b1;
               rd_addr = idx_less_two[IDX_W-1:0];
            end else begin
               state_in = SEQ_PUT;
            end
         end
         SEQ_PUT: begin
            wr_en            = 1'b1;
            wr_addr          = lo_ff[IDX_W-1:0];
            wr_data.key_high = key_high_ff;
            wr_data.key_low  = key_low_ff;
            wr_data.offset   = offset_ff;
            count_in         = count_ff + CNT_W'(1);
            state_in         = SEQ_IDLE;
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff          <= kind_in;
      key_high_ff      <= key_high_in;
      key_low_ff       <= key_low_in;
      offset_ff        <= offset_in;
      lo_ff            <= lo_in;
      hi_ff            <= hi_in;
      mid_ff           <= mid_in;
      idx_ff           <= idx_in;
      hit_ff           <= hit_in;
      hit_offset_ff    <= hit_offset_in;
      found_ff         <= found_in;
      position_ff      <= position_in;
      stored_offset_ff <= stored_offset_in;
      status_ff        <= status_in;
   end

   assign busy              = (state_ff != SEQ_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = found_ff;
   assign rsp_position      = position_ff;
   assign rsp_stored_offset = stored_offset_ff;
   assign rsp_status        = status_ff;

endmodule

>>> design/skt_entry_ram.sv
// Single write port, single read port table memory with registered read data.
// Depends on skt_pkg for the entry layout.
module skt_entry_ram
   import skt_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  entry_type                wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output entry_type                rd_data
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/skt_key_compare.sv
// Shared 128-bit unsigned key comparator used by every search step.
// Depends on skt_pkg for the key widths and result struct.
module skt_key_compare
   import skt_pkg::*;
(
   input  logic [KEY_HALF_W-1:0] stored_high,
   input  logic [KEY_HALF_W-1:0] stored_low,
   input  logic [KEY_HALF_W-1:0] probe_high,
   input  logic [KEY_HALF_W-1:0] probe_low,
   output cmp_result_type        result
);

   always_comb begin
      result.less  = {stored_high, stored_low} < {probe_high, probe_low};
      result.equal = {stored_high, stored_low} == {probe_high, probe_low};
   end

endmodule

>>> bench/testbench.sv
// Self-checking bench for the sorted key table search and insert core.
// Depends on skt_pkg and sorted_key_table_search_insert_core; it predicts every
// response with its own model of the table and compares each field.
module testbench
   import skt_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH = 64;
   localparam int TOTAL_REQUESTS = 1100;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int SETTLE_CYCLES = 100;
   localparam int REPORT_LIMIT = 10;

   localparam logic [63:0] HALF_ZERO = 64'h0;
   localparam logic [63:0] HALF_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] HALF_ONES_LESS_ONE = 64'hFFFF_FFFF_FFFF_FFFE;
   localparam logic [63:0] HALF_A = 64'hAAAA_AAAA_AAAA_AAAA;
   localparam logic [63:0] HALF_5 = 64'h5555_5555_5555_5555;

   typedef struct packed {
      logic                found;
      logic [POS_W-1:0]    position;
      logic [OFFSET_W-1:0] stored_offset;
      logic [STATUS_W-1:0] status;
   } table_reply_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic                  req_kind = KIND_LOOKUP;
   logic [KEY_HALF_W-1:0] req_key_high = '0;
   logic [KEY_HALF_W-1:0] req_key_low = '0;
   logic [OFFSET_W-1:0]   req_data_offset = '0;
   logic                  rsp_valid;
   logic                  rsp_found;
   logic [POS_W-1:0]      rsp_position;
   logic [OFFSET_W-1:0]   rsp_stored_offset;
   logic [STATUS_W-1:0]   rsp_status;

   logic [127:0]        stored_keys[TABLE_DEPTH];
   logic [OFFSET_W-1:0] stored_offsets[TABLE_DEPTH];
   int                  entry_total = 0;
   table_reply_type     expected_replies[$];
   logic [63:0]         key_high_pool[4];

   int mismatch_count = 0;
   int requests_sent = 0;
   int burst_left = 0;
   int cycle_count = 0;

   sorted_key_table_search_insert_core #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_kind(req_kind),
      .req_key_high(req_key_high),
      .req_key_low(req_key_low),
      .req_data_offset(req_data_offset),
      .rsp_valid(rsp_valid),
      .rsp_found(rsp_found),
      .rsp_position(rsp_position),
      .rsp_stored_offset(rsp_stored_offset),
      .rsp_status(rsp_status)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // The insertion point is the number of stored keys below the searched key.
   task automatic predict_table_reply(input logic kind, input logic [127:0] key,
                                      input logic [OFFSET_W-1:0] offset);
      table_reply_type reply;
      int              slot;
      slot = 0;
      while (slot < entry_total && stored_keys[slot] < key) slot++;
      reply.found = 1'b0;
      reply.position = slot[POS_W-1:0];
      reply.stored_offset = '0;
      if (slot < entry_total && stored_keys[slot] == key) begin
         reply.found = 1'b1;
         reply.stored_offset = stored_offsets[slot];
         reply.status = (kind == KIND_INSERT) ? STATUS_DUPLICATE : STATUS_OK;
      end else if (kind == KIND_LOOKUP) begin
         reply.status = STATUS_NOT_FOUND;
      end else if (entry_total >= TABLE_DEPTH) begin
         reply.status = STATUS_FULL;
      end else begin
         for (int i = entry_total; i > slot; i--) begin
            stored_keys[i] = stored_keys[i-1];
            stored_offsets[i] = stored_offsets[i-1];
         end
         stored_keys[slot] = key;
         stored_offsets[slot] = offset;
         entry_total++;
         reply.stored_offset = offset;
         reply.status = STATUS_OK;
      end
      expected_replies.push_back(reply);
   endtask

   // Called at a rising edge; returns at the taking edge or after an idle gap.
   task automatic send_request(input logic kind, input logic [127:0] key,
                               input logic [OFFSET_W-1:0] offset);
      int gap;
      req_kind <= kind;
      req_key_high <= key[127:64];
      req_key_low <= key[63:0];
      req_data_offset <= offset;
      start <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      predict_table_reply(kind, key, offset);
      requests_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         start <= 1'b0;
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 4);
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 5);
      end
   endtask

   task automatic wait_for_replies();
      start <= 1'b0;
      do @(negedge clock); while (expected_replies.size() != 0);
      @(posedge clock);
   endtask

   task automatic report_field(input string field_name, input logic [31:0] want,
                               input logic [31:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: %s expected %0h, got %0h", $time, field_name, want, got);
      end
   endtask

   always @(posedge clock) begin
      table_reply_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_replies.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("%0t: response with no request outstanding", $time);
         end else begin
            want = expected_replies.pop_front();
            report_field("found", 32'(want.found), 32'(rsp_found));
            report_field("position", 32'(want.position), 32'(rsp_position));
            report_field("stored_offset", want.stored_offset, rsp_stored_offset);
            report_field("status", 32'(want.status), 32'(rsp_status));
         end
      end
   end

   function automatic logic [127:0] pick_key();
      logic [127:0] base;
      case ($urandom_range(0, 5))
         0: return {$urandom, $urandom, $urandom, $urandom};
         1, 2: return {key_high_pool[$urandom_range(0, 3)], $urandom, $urandom};
         3: return {key_high_pool[$urandom_range(0, 3)],
                    ($urandom_range(0, 1) == 0) ? HALF_ZERO : HALF_ONES};
         default: begin
            if (entry_total == 0) return {$urandom, $urandom, $urandom, $urandom};
            base = stored_keys[$urandom_range(0, entry_total - 1)];
            return ($urandom_range(0, 1) == 0) ? base + 128'd1 : base - 128'd1;
         end
      endcase
   endfunction

   function automatic logic [127:0] pick_stored_key();
      if (entry_total == 0) return pick_key();
      return stored_keys[$urandom_range(0, entry_total - 1)];
   endfunction

   task automatic test_directed_extremes();
      send_request(KIND_LOOKUP, {HALF_ZERO, HALF_ZERO}, 32'hFFFF_FFFF);
      send_request(KIND_LOOKUP, {HALF_ONES, HALF_ONES}, 32'h0);
      send_request(KIND_INSERT, {HALF_ONES, HALF_ONES_LESS_ONE}, 32'hFFFF_FFFF);
      send_request(KIND_INSERT, {HALF_ZERO, HALF_ZERO}, 32'h0);
      send_request(KIND_INSERT, {HALF_A, HALF_5}, 32'hAAAA_AAAA);
      send_request(KIND_INSERT, {HALF_5, HALF_A}, 32'h5555_5555);
      send_request(KIND_INSERT, {HALF_ZERO, HALF_ZERO}, 32'h1234_5678);
      send_request(KIND_INSERT, {HALF_ZERO, HALF_ONES}, 32'h1);
      send_request(KIND_INSERT, {64'h1, HALF_ZERO}, 32'h2);
      send_request(KIND_LOOKUP, {HALF_ZERO, HALF_ZERO}, 32'h0);
      send_request(KIND_LOOKUP, {HALF_ZERO, HALF_ONES}, 32'h0);
      send_request(KIND_LOOKUP, {64'h1, HALF_ZERO}, 32'h0);
      send_request(KIND_LOOKUP, {HALF_A, HALF_5}, 32'h0);
      send_request(KIND_LOOKUP, {HALF_5, HALF_A}, 32'hFFFF_FFFF);
      send_request(KIND_LOOKUP, {HALF_ONES, HALF_ONES_LESS_ONE}, 32'h0);
      send_request(KIND_LOOKUP, {HALF_A, HALF_5 + 64'h1}, 32'h0);
      send_request(KIND_LOOKUP, {HALF_ONES, HALF_ONES}, 32'h0);
      wait_for_replies();
   endtask

   task automatic test_fill_to_capacity();
      int choice;
      while (entry_total < TABLE_DEPTH) begin
         choice = $urandom_range(0, 99);
         if (choice < 50)
            send_request(KIND_INSERT, pick_key(), $urandom);
         else if (choice < 65)
            send_request(KIND_INSERT, pick_stored_key(), $urandom);
         else if (choice < 85)
            send_request(KIND_LOOKUP, pick_stored_key(), $urandom);
         else
            send_request(KIND_LOOKUP, pick_key(), $urandom);
      end
      wait_for_replies();
   endtask

   task automatic test_full_table();
      int choice;
      send_request(KIND_LOOKUP, {HALF_ONES, HALF_ONES}, 32'h0);
      send_request(KIND_INSERT, {HALF_ONES, HALF_ONES}, 32'hFFFF_FFFF);
      send_request(KIND_LOOKUP, {HALF_ZERO, HALF_ZERO}, 32'h0);
      send_request(KIND_INSERT, {HALF_ZERO, HALF_ZERO}, 32'hFFFF_FFFF);
      while (requests_sent < TOTAL_REQUESTS) begin
         choice = $urandom_range(0, 99);
         if (choice < 40)
            send_request(KIND_LOOKUP, pick_stored_key(), $urandom);
         else if (choice < 65)
            send_request(KIND_LOOKUP, pick_key(), $urandom);
         else if (choice < 85)
            send_request(KIND_INSERT, pick_key(), $urandom);
         else
            send_request(KIND_INSERT, pick_stored_key(), $urandom);
         if ($urandom_range(0, 149) == 0) wait_for_replies();
      end
   endtask

   initial begin
      key_high_pool[0] = HALF_ZERO;
      key_high_pool[1] = HALF_ONES;
      key_high_pool[2] = {$urandom, $urandom};
      key_high_pool[3] = {$urandom, $urandom};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed_extremes();
      test_fill_to_capacity();
      test_full_table();
      wait_for_replies();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
